>>> rtl/pvh_pkg.sv
// Package for the point voxel histogram: grid sizes, address widths,
// register map codes and shared types. No dependencies.
`default_nettype none
package pvh_pkg;
    localparam int GRID_X_MAX  = 64;
    localparam int GRID_Y_MAX  = 64;
    localparam int GRID_Z_MAX  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int XB          = $clog2(GRID_X_MAX);
    localparam int YB          = $clog2(GRID_Y_MAX);
    localparam int ZB          = $clog2(GRID_Z_MAX);
    localparam int ADDR_BITS   = XB + YB + ZB;
    localparam int DEPTH       = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
    localparam int COORD_BITS  = 24;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SIZE_BITS   = 16;
    localparam int PADDR_BITS  = 5;

    typedef enum logic [2:0] {
        t_reg_min_x = 3'd0, t_reg_min_y = 3'd1, t_reg_min_z = 3'd2,
        t_reg_vsize = 3'd3, t_reg_grid_x = 3'd4, t_reg_grid_y = 3'd5,
        t_reg_grid_z = 3'd6, t_reg_none = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        t_st_clear, t_st_idle, t_st_div, t_st_read, t_st_write
    } t_state;

    // Request from the control unit to the counter memory.
    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [ADDR_BITS-1:0] addr;
        logic [COUNT_BITS-1:0] wdata;
    } t_mem_req;
endpackage
`default_nettype wire

>>> rtl/point_voxel_histogram.sv
// Top level of the point voxel histogram: APB registers, control sequencer,
// divider and counter memory. Depends on pvh_pkg, pvh_div, pvh_mem.
`default_nettype none
// A point passes through these steps: the accepting cycle, a divider load
// cycle, the bit-serial divider (one quotient bit per cycle, all three axes
// together), a cycle that checks the grid and issues the memory read, the
// read-data cycle and the write-back cycle that also shows the result. A point
// that misses the grid shows its all-zero result in the check cycle. An
// end-of-frame transaction clears the counter memory by a sweep of one entry
// per cycle over all 65536 entries, then shows its all-zero result. After reset
// the same clearing pass runs with busy high; configuration writes are taken
// throughout. Each result is on the output ports for one cycle, marked by
// o_valid; the receiver cannot stall it, so it must take every strobe.
module point_voxel_histogram (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [pvh_pkg::PADDR_BITS-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_action,
    input  wire logic signed [23:0] i_x_coord,
    input  wire logic signed [23:0] i_y_coord,
    input  wire logic signed [23:0] i_z_coord,
    output logic             o_valid,
    output logic             o_in_range,
    output logic [5:0]       o_voxel_x,
    output logic [5:0]       o_voxel_y,
    output logic [3:0]       o_voxel_z,
    output logic [15:0]      o_count
);
    localparam int NB = pvh_pkg::DIFF_BITS - 1;
    localparam int CB = pvh_pkg::COUNT_BITS;
    localparam int AB = pvh_pkg::ADDR_BITS;
    localparam int DCB = $clog2(NB + 2);
    localparam int DIV_LAST = NB + 1;

    // Configuration registers.
    logic signed [23:0] r_min_x, r_min_y, r_min_z;
    logic [15:0] r_vsize;
    logic [6:0]  r_grid_x, r_grid_y;
    logic [4:0]  r_grid_z;
    pvh_pkg::t_reg reg_sel;

    assign pready = 1'b1;
    assign reg_sel = (paddr[4:2] == 3'd7) ? pvh_pkg::t_reg_none : pvh_pkg::t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x  <= -24'sd300000;
            r_min_y  <= -24'sd200000;
            r_min_z  <= -24'sd100000;
            r_vsize  <= 16'd100;
            r_grid_x <= 7'd64;
            r_grid_y <= 7'd64;
            r_grid_z <= 5'd16;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                pvh_pkg::t_reg_min_x:  r_min_x  <= pwdata[23:0];
                pvh_pkg::t_reg_min_y:  r_min_y  <= pwdata[23:0];
                pvh_pkg::t_reg_min_z:  r_min_z  <= pwdata[23:0];
                pvh_pkg::t_reg_vsize:  r_vsize  <= pwdata[15:0];
                pvh_pkg::t_reg_grid_x: r_grid_x <= pwdata[6:0];
                pvh_pkg::t_reg_grid_y: r_grid_y <= pwdata[6:0];
                pvh_pkg::t_reg_grid_z: r_grid_z <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            pvh_pkg::t_reg_min_x:  prdata = {{8{r_min_x[23]}}, r_min_x};
            pvh_pkg::t_reg_min_y:  prdata = {{8{r_min_y[23]}}, r_min_y};
            pvh_pkg::t_reg_min_z:  prdata = {{8{r_min_z[23]}}, r_min_z};
            pvh_pkg::t_reg_vsize:  prdata = {16'd0, r_vsize};
            pvh_pkg::t_reg_grid_x: prdata = {25'd0, r_grid_x};
            pvh_pkg::t_reg_grid_y: prdata = {25'd0, r_grid_y};
            pvh_pkg::t_reg_grid_z: prdata = {27'd0, r_grid_z};
            default:               prdata = '0;
        endcase
    end

    // Sequencer state.
    pvh_pkg::t_state r_state, n_state;
    logic [AB-1:0]   r_clr_addr;
    logic [DCB-1:0]  r_div_cnt;
    logic            r_neg;       // any axis below its minimum
    logic [NB-1:0]   r_diff [3];
    logic            r_clr_done;  // end-of-frame sweep, result owed

    // Differences, captured on accept; negative flagged.
    logic signed [NB:0] diff_x, diff_y, diff_z;
    assign diff_x = {i_x_coord[23], i_x_coord} - {r_min_x[23], r_min_x};
    assign diff_y = {i_y_coord[23], i_y_coord} - {r_min_y[23], r_min_y};
    assign diff_z = {i_z_coord[23], i_z_coord} - {r_min_z[23], r_min_z};

    logic accept;
    assign accept = start && !busy;

    logic [NB-1:0] q_x, q_y, q_z;
    pvh_div u_div (
        .i_clk   (i_clk),
        .i_load  (r_state == pvh_pkg::t_st_div && r_div_cnt == '0),
        .i_en    (r_state == pvh_pkg::t_st_div && r_div_cnt != DCB'(DIV_LAST)),
        .i_num_x (r_diff[0]),
        .i_num_y (r_diff[1]),
        .i_num_z (r_diff[2]),
        .i_den   (r_vsize),
        .o_q_x   (q_x),
        .o_q_y   (q_y),
        .o_q_z   (q_z)
    );

    // Effective limits, clamped to the grid maxima.
    logic [6:0] lim_x, lim_y;
    logic [4:0] lim_z;
    assign lim_x = (r_grid_x > 7'(pvh_pkg::GRID_X_MAX)) ? 7'(pvh_pkg::GRID_X_MAX) : r_grid_x;
    assign lim_y = (r_grid_y > 7'(pvh_pkg::GRID_Y_MAX)) ? 7'(pvh_pkg::GRID_Y_MAX) : r_grid_y;
    assign lim_z = (r_grid_z > 5'(pvh_pkg::GRID_Z_MAX)) ? 5'(pvh_pkg::GRID_Z_MAX) : r_grid_z;

    logic hit;
    assign hit = !r_neg && (q_x < NB'(lim_x)) && (q_y < NB'(lim_y)) && (q_z < NB'(lim_z));

    logic [AB-1:0] vaddr;
    assign vaddr = {q_x[pvh_pkg::XB-1:0], q_y[pvh_pkg::YB-1:0], q_z[pvh_pkg::ZB-1:0]};

    logic [CB-1:0] rdata, inc;
    assign inc = (rdata == {CB{1'b1}}) ? rdata : rdata + CB'(1);

    pvh_pkg::t_mem_req mreq;
    pvh_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rdata(rdata));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pvh_pkg::t_st_clear: if (r_clr_addr == {AB{1'b1}}) n_state = pvh_pkg::t_st_idle;
            pvh_pkg::t_st_idle: begin
                if (accept) n_state = i_action ? pvh_pkg::t_st_clear : pvh_pkg::t_st_div;
            end
            // Count 0 loads the divider, then NB shift steps; the last count
            // checks the grid.
            pvh_pkg::t_st_div: if (r_div_cnt == DCB'(DIV_LAST)) begin
                n_state = hit ? pvh_pkg::t_st_read : pvh_pkg::t_st_idle;
            end
            pvh_pkg::t_st_read:  n_state = pvh_pkg::t_st_write;
            pvh_pkg::t_st_write: n_state = pvh_pkg::t_st_idle;
            default:             n_state = pvh_pkg::t_st_idle;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        mreq  = '0;
        busy  = 1'b1;
        o_valid    = 1'b0;
        o_in_range = 1'b0;
        o_voxel_x  = '0;
        o_voxel_y  = '0;
        o_voxel_z  = '0;
        o_count    = '0;
        unique case (r_state)
            pvh_pkg::t_st_clear: begin
                mreq.wr   = 1'b1;
                mreq.addr = r_clr_addr;
            end
            pvh_pkg::t_st_idle: begin
                busy    = 1'b0;
                o_valid = r_clr_done;   // end of frame finished
            end
            pvh_pkg::t_st_div: begin
                // Drop an out-of-range point with an all-zero result.
                o_valid = (r_div_cnt == DCB'(DIV_LAST)) && !hit;
                mreq.rd   = (r_div_cnt == DCB'(DIV_LAST)) && hit;
                mreq.addr = vaddr;
            end
            pvh_pkg::t_st_read: begin
                mreq.addr = vaddr;
            end
            pvh_pkg::t_st_write: begin
                mreq.wr    = 1'b1;
                mreq.addr  = vaddr;
                mreq.wdata = inc;
                o_valid    = 1'b1;
                o_in_range = 1'b1;
                o_voxel_x  = 6'(q_x);
                o_voxel_y  = 6'(q_y);
                o_voxel_z  = 4'(q_z);
                o_count    = 16'(inc);
            end
            default: ;
        endcase
    end

    // Read data arrives during t_st_read; it holds through write.
    // The divider stops shifting once the count is done, so the quotient and
    // the voxel index hold through read and write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pvh_pkg::t_st_clear;
            r_clr_addr <= '0;
            r_div_cnt  <= '0;
            r_clr_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pvh_pkg::t_st_clear) r_clr_addr <= r_clr_addr + AB'(1);
            else r_clr_addr <= '0;
            if (r_state == pvh_pkg::t_st_div) r_div_cnt <= r_div_cnt + DCB'(1);
            else r_div_cnt <= '0;
            r_clr_done <= (r_state == pvh_pkg::t_st_idle) ? (accept && i_action)
                        : (r_state == pvh_pkg::t_st_clear) ? r_clr_done : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff[0] <= diff_x[NB-1:0];
            r_diff[1] <= diff_y[NB-1:0];
            r_diff[2] <= diff_z[NB-1:0];
            r_neg     <= diff_x[NB] || diff_y[NB] || diff_z[NB];
        end
    end
endmodule
`default_nettype wire

>>> rtl/pvh_div.sv
// Restoring divider: one quotient bit per cycle while i_en is high,
// three axes in parallel. Depends on pvh_pkg.
`default_nettype none
module pvh_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_load,
    input  wire logic                                i_en,
    input  wire logic [pvh_pkg::DIFF_BITS-2:0]       i_num_x,
    input  wire logic [pvh_pkg::DIFF_BITS-2:0]       i_num_y,
    input  wire logic [pvh_pkg::DIFF_BITS-2:0]       i_num_z,
    input  wire logic [pvh_pkg::SIZE_BITS-1:0]       i_den,
    output logic      [pvh_pkg::DIFF_BITS-2:0]       o_q_x,
    output logic      [pvh_pkg::DIFF_BITS-2:0]       o_q_y,
    output logic      [pvh_pkg::DIFF_BITS-2:0]       o_q_z
);
    localparam int NB = pvh_pkg::DIFF_BITS - 1;
    localparam int RB = pvh_pkg::SIZE_BITS + 1;
    logic [NB-1:0] r_q [3];
    logic [RB-1:0] r_rem [3];
    logic [NB-1:0] r_den_hold;
    logic [NB-1:0] n_q [3];
    logic [RB-1:0] n_rem [3];
    logic [RB-1:0] trial [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            trial[a] = {r_rem[a][RB-2:0], r_q[a][NB-1]};
            if (trial[a] >= {1'b0, r_den_hold[pvh_pkg::SIZE_BITS-1:0]}) begin
                n_rem[a] = trial[a] - {1'b0, r_den_hold[pvh_pkg::SIZE_BITS-1:0]};
                n_q[a]   = {r_q[a][NB-2:0], 1'b1};
            end else begin
                n_rem[a] = trial[a];
                n_q[a]   = {r_q[a][NB-2:0], 1'b0};
            end
        end
    end

    // Hold the quotient whenever neither a load nor a shift is enabled.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q[0] <= i_num_x;
            r_q[1] <= i_num_y;
            r_q[2] <= i_num_z;
            for (int a = 0; a < 3; a++) r_rem[a] <= '0;
            r_den_hold <= {{(NB-pvh_pkg::SIZE_BITS){1'b0}},
                           (i_den == '0) ? pvh_pkg::SIZE_BITS'(1) : i_den};
        end else if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r_q[a]   <= n_q[a];
                r_rem[a] <= n_rem[a];
            end
        end
    end

    assign o_q_x = r_q[0];
    assign o_q_y = r_q[1];
    assign o_q_z = r_q[2];
endmodule
`default_nettype wire

>>> rtl/pvh_mem.sv
// Counter store: single-port synchronous RAM, registered read data.
// Depends on pvh_pkg.
`default_nettype none
module pvh_mem (
    input  wire logic                              i_clk,
    input  wire pvh_pkg::t_mem_req                 i_req,
    output logic      [pvh_pkg::COUNT_BITS-1:0]    o_rdata
);
    logic [pvh_pkg::COUNT_BITS-1:0] r_ram [pvh_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) r_ram[i_req.addr] <= i_req.wdata;
        if (i_req.rd) o_rdata <= r_ram[i_req.addr];
    end
endmodule
`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for point_voxel_histogram: random and directed points
// and end-of-frame commands, checked against a behavioral voxel counter.
// Depends on pvh_pkg and the RTL of the block.
`timescale 1ns / 1ps

typedef struct {
    logic        in_range;
    logic [5:0]  vx;
    logic [5:0]  vy;
    logic [3:0]  vz;
    logic [15:0] count;
} voxel_hit_t;

// Tracks register contents and voxel counters, predicts each result and
// checks what the block produces in order.
class voxel_scoreboard;
    logic [23:0] lo_x, lo_y, lo_z;
    logic [15:0] edge_mm;
    logic [6:0]  nx, ny;
    logic [4:0]  nz;
    int          counts[int];
    voxel_hit_t  pending[$];
    int          errors;

    function new();
        lo_x = -24'sd300000;
        lo_y = -24'sd200000;
        lo_z = -24'sd100000;
        edge_mm = 16'd100;
        nx = 7'd64;
        ny = 7'd64;
        nz = 5'd16;
        errors = 0;
    endfunction

    function void set_reg(pvh_pkg::t_reg idx, logic [31:0] v);
        case (idx)
            pvh_pkg::t_reg_min_x:  lo_x = v[23:0];
            pvh_pkg::t_reg_min_y:  lo_y = v[23:0];
            pvh_pkg::t_reg_min_z:  lo_z = v[23:0];
            pvh_pkg::t_reg_vsize:  edge_mm = v[15:0];
            pvh_pkg::t_reg_grid_x: nx = v[6:0];
            pvh_pkg::t_reg_grid_y: ny = v[6:0];
            pvh_pkg::t_reg_grid_z: nz = v[4:0];
            default: ;
        endcase
    endfunction

    // Floor index on one axis, or -1 when the point misses the axis.
    function longint axis_bin(logic [23:0] c, logic [23:0] m, int n, int nmax);
        longint d, sz, lim;
        d = longint'($signed(c)) - longint'($signed(m));
        sz = (edge_mm == 0) ? 1 : longint'(edge_mm);
        lim = (n > nmax) ? nmax : n;
        if (d < 0) return -1;
        if (d / sz >= lim) return -1;
        return d / sz;
    endfunction

    function void note_item(logic eof, logic [23:0] x, logic [23:0] y,
                            logic [23:0] z);
        voxel_hit_t h;
        longint ix, iy, iz;
        int addr;
        h = '{1'b0, 6'd0, 6'd0, 4'd0, 16'd0};
        if (eof) begin
            counts.delete();
        end else begin
            ix = axis_bin(x, lo_x, nx, pvh_pkg::GRID_X_MAX);
            iy = axis_bin(y, lo_y, ny, pvh_pkg::GRID_Y_MAX);
            iz = axis_bin(z, lo_z, nz, pvh_pkg::GRID_Z_MAX);
            if (ix >= 0 && iy >= 0 && iz >= 0) begin
                addr = int'((ix * pvh_pkg::GRID_Y_MAX + iy) * pvh_pkg::GRID_Z_MAX + iz);
                if (!counts.exists(addr)) counts[addr] = 0;
                if (counts[addr] < 65535) counts[addr]++;
                h = '{1'b1, ix[5:0], iy[5:0], iz[3:0], counts[addr][15:0]};
            end
        end
        pending.push_back(h);
    endfunction

    function void check_result(voxel_hit_t got);
        voxel_hit_t e;
        if (pending.size() == 0) begin
            $error("result with nothing expected");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.in_range !== e.in_range) begin
            $error("in_range: expected %0d, got %0d", e.in_range, got.in_range);
            errors++;
        end
        if (got.vx !== e.vx) begin
            $error("voxel_x: expected %0d, got %0d", e.vx, got.vx);
            errors++;
        end
        if (got.vy !== e.vy) begin
            $error("voxel_y: expected %0d, got %0d", e.vy, got.vy);
            errors++;
        end
        if (got.vz !== e.vz) begin
            $error("voxel_z: expected %0d, got %0d", e.vz, got.vz);
            errors++;
        end
        if (got.count !== e.count) begin
            $error("count: expected %0d, got %0d", e.count, got.count);
            errors++;
        end
    endfunction
endclass

module testbench;
    import pvh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        i_action;
    logic signed [23:0] i_x_coord, i_y_coord, i_z_coord;
    logic        o_valid, o_in_range;
    logic [5:0]  o_voxel_x, o_voxel_y;
    logic [3:0]  o_voxel_z;
    logic [15:0] o_count;

    voxel_scoreboard sb;
    int          run_len;   // items left in the current sender burst

    point_voxel_histogram u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_action(i_action), .i_x_coord(i_x_coord), .i_y_coord(i_y_coord),
        .i_z_coord(i_z_coord),
        .o_valid(o_valid), .o_in_range(o_in_range), .o_voxel_x(o_voxel_x),
        .o_voxel_y(o_voxel_y), .o_voxel_z(o_voxel_z), .o_count(o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Take every strobed result; the block cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{o_in_range, o_voxel_x, o_voxel_y, o_voxel_z, o_count});
    end

    // Two-phase register write: setup, then access until pready.
    task automatic reg_write(t_reg idx, logic [31:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PADDR_BITS'(idx) << 2;
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Present one transaction and hold it until accepted; between bursts
    // drop start for a random gap.
    task automatic send(logic eof, logic [23:0] x, logic [23:0] y, logic [23:0] z);
        int gap;
        @(negedge i_clk);
        start = 1'b1;
        i_action = eof;
        i_x_coord = x;
        i_y_coord = y;
        i_z_coord = z;
        do @(posedge i_clk); while (busy);
        sb.note_item(eof, x, y, z);
        if (run_len > 0) begin
            run_len--;
        end else begin
            run_len = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop start, then wait until every expected result is in.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Coordinate that lands in a chosen voxel on an axis with the current setup.
    function automatic logic [23:0] aim(logic [23:0] m, int n, int nmax);
        longint sz, lim, c;
        sz = (sb.edge_mm == 0) ? 1 : longint'(sb.edge_mm);
        lim = (n > nmax) ? nmax : n;
        if (lim == 0) return 24'($urandom);
        c = longint'($signed(m)) + longint'($urandom_range(0, int'(lim - 1))) * sz
            + longint'($urandom_range(0, int'(sz - 1)));
        return c[23:0];
    endfunction

    task automatic random_point();
        logic [23:0] x, y, z;
        x = aim(sb.lo_x, sb.nx, GRID_X_MAX);
        y = aim(sb.lo_y, sb.ny, GRID_Y_MAX);
        z = aim(sb.lo_z, sb.nz, GRID_Z_MAX);
        // Knock one axis off the grid now and then, or send pure noise.
        case ($urandom_range(0, 9))
            0: x = 24'($urandom);
            1: y = 24'($urandom);
            2: z = 24'($urandom);
            3: begin
                x = 24'($urandom);
                y = 24'($urandom);
                z = 24'($urandom);
            end
            default: ;
        endcase
        send(1'b0, x, y, z);
    endtask

    function automatic logic [31:0] pick_grid(int top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return top;
            3: return (top == 16) ? 31 : 127;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 65535;
            default: return $urandom_range(2, 3000);
        endcase
    endfunction

    initial begin
        sb = new();
        run_len = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        i_action = 1'b0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_z_coord = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: defaults first (x grid spans -300000..-293600, etc.).
        send(1'b0, -24'sd300000, -24'sd200000, -24'sd100000);
        send(1'b0, -24'sd300000, -24'sd200000, -24'sd100000);
        send(1'b0, -24'sd300001, 24'sd0, 24'sd0);           // below x minimum
        send(1'b0, 24'sd0, -24'sd200001, 24'sd0);           // below y minimum
        send(1'b0, 24'sd0, 24'sd0, -24'sd100001);           // below z minimum
        send(1'b0, -24'sd293601, -24'sd193601, -24'sd98401); // last voxel
        send(1'b0, -24'sd293600, 24'sd0, 24'sd0);           // just past x grid
        send(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send(1'b0, 24'h800000, 24'h800000, 24'h800000);
        send(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);     // end of frame
        send(1'b0, -24'sd300000, -24'sd200000, -24'sd100000); // count restarts
        drain();

        // Directed: extreme settings.
        reg_write(t_reg_min_x, 32'h0080_0000);
        reg_write(t_reg_min_y, 32'h007F_FFFF);
        reg_write(t_reg_min_z, 32'h0080_0000);
        reg_write(t_reg_vsize, 32'd0);      // zero size acts as one
        reg_write(t_reg_grid_x, 32'd127);   // clamped to the maximum
        reg_write(t_reg_grid_y, 32'd1);
        reg_write(t_reg_grid_z, 32'd31);
        reg_write(t_reg_none, 32'hFFFF_FFFF); // unknown index, ignored
        send(1'b0, 24'h800000, 24'h7FFFFF, 24'h80000F);
        send(1'b0, 24'h80003F, 24'h7FFFFF, 24'h80000F);
        send(1'b0, 24'h800040, 24'h7FFFFF, 24'h800000);
        send(1'b0, 24'h800001, 24'h7FFFFE, 24'h800000);
        drain();
        reg_write(t_reg_vsize, 32'd65535);
        reg_write(t_reg_grid_y, 32'd0);     // nothing can land
        send(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000);
        drain();
        reg_write(t_reg_grid_y, 32'd64);
        send(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        drain();

        // Random phases, each with fresh settings and few frame ends.
        for (int ph = 0; ph < 7; ph++) begin
            reg_write(t_reg_min_x, $urandom_range(0, 1) ? 32'($urandom) : 32'hFFFF_FF00);
            reg_write(t_reg_min_y, $urandom_range(0, 1) ? 32'($urandom) : 32'h0000_0010);
            reg_write(t_reg_min_z, 32'($urandom));
            reg_write(t_reg_vsize, pick_size());
            reg_write(t_reg_grid_x, pick_grid(64));
            reg_write(t_reg_grid_y, pick_grid(64));
            reg_write(t_reg_grid_z, pick_grid(16));
            for (int k = 0; k < 62; k++) begin
                if ($urandom_range(0, 99) == 0)
                    send(1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
                else
                    random_point();
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Clearing passes sweep all 65536 entries; allow far more time than needed.
    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> sim.f
rtl/pvh_pkg.sv
rtl/pvh_div.sv
rtl/pvh_mem.sv
rtl/point_voxel_histogram.sv
verif/testbench.sv
